// ===== hw/rtl/vrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video register port package
// Shared types, opcodes, store depths and memory map constants.
// ----------------------------------------------------------------------------
package vrp_pkg;

    // Store depths. Pattern and name depths must be powers of two.
    localparam int PATTERN_DEPTH = 8192;
    localparam int NAME_DEPTH    = 2048;
    localparam int SPRITE_DEPTH  = 256;
    localparam int PALETTE_DEPTH = 32;

    localparam int PATTERN_AW = $clog2(PATTERN_DEPTH);
    localparam int NAME_AW    = $clog2(NAME_DEPTH);
    localparam int SPRITE_AW  = $clog2(SPRITE_DEPTH);
    localparam int PALETTE_AW = $clog2(PALETTE_DEPTH);

    // Opcodes.
    localparam logic [2:0] OP_READ_STATUS  = 3'd0;
    localparam logic [2:0] OP_READ_SPRITE  = 3'd1;
    localparam logic [2:0] OP_READ_DATA    = 3'd2;
    localparam logic [2:0] OP_WRITE_SCROLL = 3'd3;
    localparam logic [2:0] OP_WRITE_ADDR   = 3'd4;
    localparam logic [2:0] OP_WRITE_DATA   = 3'd5;
    localparam logic [2:0] OP_WRITE_SPRITE = 3'd6;
    localparam logic [2:0] OP_LOAD_PATTERN = 3'd7;

    // Video memory map.
    localparam logic [15:0] NAME_BASE    = 16'h2000;
    localparam logic [15:0] PALETTE_BASE = 16'h3F00;
    localparam logic [15:0] VRAM_LIMIT   = 16'h4000;

    localparam logic [7:0]  STATUS_SET   = 8'hC0;
    localparam logic [15:0] STEP_ONE     = 16'd1;
    localparam logic [15:0] STEP_ROW     = 16'd32;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  data_byte;
        logic [7:0]  sprite_index;
        logic [12:0] pattern_address;
    } request_t;

    typedef struct packed {
        logic [7:0]  read_value;
        logic [7:0]  scroll_horizontal;
        logic [7:0]  scroll_vertical;
        logic [15:0] video_address;
    } result_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear;
        logic fetch;
        logic exec;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

// ===== hw/rtl/video_register_port.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video register port
// CPU-facing register port with pattern, name, palette and sprite stores.
// ----------------------------------------------------------------------------
// An accepted start fetches the access from the stores, the execute state updates
// it, and the done register then pulses done. No new access is taken while busy;
// the next one is accepted once the port is back in idle.
// Reset: busy stays high while the name, palette and sprite stores are cleared
// over NAME_DEPTH (2048) addresses; configuration writes are taken meanwhile.
// The receiver cannot stall: each result is valid for the single done cycle.
module video_register_port (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vrp_pkg::request_t request,
    output logic              done,
    output vrp_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import vrp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The user must change configuration only while idle; the block does not enforce this. It is always accepted.
    assign cfg_ready = 1'b1;

    vrp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    vrp_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .request  (request),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

// ===== hw/rtl/vrp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video register port controller
// Sequences the store clearing pass, the fetch of an access and its update.
// ----------------------------------------------------------------------------
module vrp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  vrp_pkg::dp_status_t status,
    output vrp_pkg::ctrl_cmd_t cmd,
    output logic               busy,
    output logic               done
);
    import vrp_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cmd.clear = (state_reg == S_CLEAR);
    assign cmd.fetch = (state_reg == S_IDLE) && start;
    assign cmd.exec  = (state_reg == S_EXEC);
    assign done      = done_reg;

endmodule

// ===== hw/rtl/vrp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video register port datapath
// Stores, address and scroll registers, read buffer and result register.
// ----------------------------------------------------------------------------
module vrp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  vrp_pkg::ctrl_cmd_t  cmd,
    output vrp_pkg::dp_status_t status,
    input  vrp_pkg::request_t   request,
    input  logic                cfg_we,
    input  logic                cfg_data,
    output vrp_pkg::result_t    result
);
    import vrp_pkg::*;

    // Fold 0x10, 0x14, 0x18 and 0x1C onto the background entries.
    function automatic logic [PALETTE_AW-1:0] pal_slot(input logic [15:0] a);
        logic [PALETTE_AW-1:0] s;
        s = a[PALETTE_AW-1:0];
        if (s[PALETTE_AW-1] && (s[1:0] == 2'b00))
        begin
            s[PALETTE_AW-1] = 1'b0;
        end
        return s;
    endfunction

    logic [7:0] pattern_mem [PATTERN_DEPTH];
    logic [7:0] name_mem    [NAME_DEPTH];
    logic [7:0] palette_mem [PALETTE_DEPTH];
    logic [7:0] sprite_mem  [SPRITE_DEPTH];

    logic [15:0]        addr_reg,     addr_next;
    logic [7:0]         buffer_reg,   buffer_next;
    logic               toggle_reg,   toggle_next;
    logic               phase_reg,    phase_next;
    logic [7:0]         scroll_x_reg, scroll_x_next;
    logic [7:0]         scroll_y_reg, scroll_y_next;
    logic               inc32_reg,    inc32_next;
    logic [NAME_AW-1:0] clear_cnt_reg, clear_cnt_next;

    // Latched access, no reset needed.
    logic [2:0]            op_reg;
    logic [7:0]            data_reg;
    logic [SPRITE_AW-1:0]  sidx_reg;
    logic [PATTERN_AW-1:0] paddr_reg;

    logic [7:0] pattern_q, name_q, palette_q, sprite_q;
    result_t    result_reg;
    logic [7:0] read_value;
    logic [7:0] mem_value;

    logic in_pattern, in_name, in_palette;

    logic                  pattern_we;
    logic                  name_we;
    logic [NAME_AW-1:0]    name_wa;
    logic [7:0]            name_wd;
    logic                  palette_we;
    logic [PALETTE_AW-1:0] palette_wa;
    logic [7:0]            palette_wd;
    logic                  sprite_we;
    logic [SPRITE_AW-1:0]  sprite_wa;
    logic [7:0]            sprite_wd;

    assign in_pattern = (addr_reg < NAME_BASE);
    assign in_name    = !in_pattern && (addr_reg < PALETTE_BASE);
    assign in_palette = (addr_reg >= PALETTE_BASE) && (addr_reg < VRAM_LIMIT);

    assign status.clear_last = (clear_cnt_reg == NAME_AW'(NAME_DEPTH - 1));

    always_comb
    begin
        if (in_pattern)
        begin
            mem_value = pattern_q;
        end
        else if (in_name)
        begin
            mem_value = name_q;
        end
        else if (in_palette)
        begin
            mem_value = palette_q;
        end
        else
        begin
            mem_value = 8'd0;
        end
    end

    // Store writes: the clearing pass writes zeros, an access writes its byte.
    always_comb
    begin
        pattern_we = cmd.exec && (op_reg == OP_LOAD_PATTERN);
        name_we    = cmd.clear || (cmd.exec && (op_reg == OP_WRITE_DATA) && in_name);
        palette_we = cmd.clear || (cmd.exec && (op_reg == OP_WRITE_DATA) && in_palette);
        sprite_we  = cmd.clear || (cmd.exec && (op_reg == OP_WRITE_SPRITE));
        if (cmd.clear)
        begin
            name_wa    = clear_cnt_reg;
            name_wd    = 8'd0;
            palette_wa = clear_cnt_reg[PALETTE_AW-1:0];
            palette_wd = 8'd0;
            sprite_wa  = clear_cnt_reg[SPRITE_AW-1:0];
            sprite_wd  = 8'd0;
        end
        else
        begin
            name_wa    = addr_reg[NAME_AW-1:0];
            name_wd    = data_reg;
            palette_wa = pal_slot(addr_reg);
            palette_wd = data_reg;
            sprite_wa  = sidx_reg;
            sprite_wd  = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pattern_we)
        begin
            pattern_mem[paddr_reg] <= data_reg;
        end
        if (cmd.fetch)
        begin
            pattern_q <= pattern_mem[addr_reg[PATTERN_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[name_wa] <= name_wd;
        end
        if (cmd.fetch)
        begin
            name_q <= name_mem[addr_reg[NAME_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (palette_we)
        begin
            palette_mem[palette_wa] <= palette_wd;
        end
        if (cmd.fetch)
        begin
            palette_q <= palette_mem[pal_slot(addr_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sprite_we)
        begin
            sprite_mem[sprite_wa] <= sprite_wd;
        end
        if (cmd.fetch)
        begin
            sprite_q <= sprite_mem[request.sprite_index[SPRITE_AW-1:0]];
        end
    end

    always_comb
    begin
        addr_next      = addr_reg;
        buffer_next    = buffer_reg;
        toggle_next    = toggle_reg;
        phase_next     = phase_reg;
        scroll_x_next  = scroll_x_reg;
        scroll_y_next  = scroll_y_reg;
        inc32_next     = cfg_we ? cfg_data : inc32_reg;
        clear_cnt_next = cmd.clear ? clear_cnt_reg + NAME_AW'(1) : clear_cnt_reg;
        read_value     = 8'd0;
        if (cmd.exec)
        begin
            case (op_reg)
                OP_READ_STATUS:
                begin
                    phase_next  = !phase_reg;
                    toggle_next = 1'b0;
                    read_value  = phase_reg ? STATUS_SET : 8'd0;
                end
                OP_READ_SPRITE:
                begin
                    read_value = sprite_q;
                end
                OP_READ_DATA:
                begin
                    read_value  = buffer_reg;
                    buffer_next = mem_value;
                    addr_next   = addr_reg + (inc32_reg ? STEP_ROW : STEP_ONE);
                end
                OP_WRITE_SCROLL:
                begin
                    if (toggle_reg)
                    begin
                        scroll_y_next = data_reg;
                    end
                    else
                    begin
                        scroll_x_next = data_reg;
                    end
                    toggle_next = !toggle_reg;
                end
                OP_WRITE_ADDR:
                begin
                    if (toggle_reg)
                    begin
                        addr_next = {addr_reg[15:8], data_reg};
                    end
                    else
                    begin
                        addr_next = {data_reg, addr_reg[7:0]};
                    end
                    toggle_next = !toggle_reg;
                end
                OP_WRITE_DATA:
                begin
                    addr_next = addr_reg + (inc32_reg ? STEP_ROW : STEP_ONE);
                end
                default:
                begin
                    // Sprite writes and pattern loads only touch their stores.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= 16'd0;
            buffer_reg    <= 8'd0;
            toggle_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            scroll_x_reg  <= 8'd0;
            scroll_y_reg  <= 8'd0;
            inc32_reg     <= 1'b0;
            clear_cnt_reg <= '0;
        end
        else
        begin
            addr_reg      <= addr_next;
            buffer_reg    <= buffer_next;
            toggle_reg    <= toggle_next;
            phase_reg     <= phase_next;
            scroll_x_reg  <= scroll_x_next;
            scroll_y_reg  <= scroll_y_next;
            inc32_reg     <= inc32_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            op_reg    <= request.opcode;
            data_reg  <= request.data_byte;
            sidx_reg  <= request.sprite_index[SPRITE_AW-1:0];
            paddr_reg <= request.pattern_address[PATTERN_AW-1:0];
        end
        if (cmd.exec)
        begin
            result_reg.read_value        <= read_value;
            result_reg.scroll_horizontal <= scroll_x_next;
            result_reg.scroll_vertical   <= scroll_y_next;
            result_reg.video_address     <= addr_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== hw/rtl/vrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video register port checker
// Port-level timing checks, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module vrp_assertions (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // An accepted access makes the port busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("port not busy after an accepted transfer");

    // Every accepted access completes: done follows its execute state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result missing two cycles after accepted transfer");

    // A result only follows a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // One access at a time: results never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(done))
        else $error("back to back results");

endmodule

bind video_register_port vrp_assertions u_vrp_assertions (.*);

// ===== verif/vrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video register port checker
// Watches the access, result and control channels of the port. It keeps its
// own copy of the stores and registers, predicts each result, and compares.
// ----------------------------------------------------------------------------
module vrp_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  vrp_pkg::request_t request,
    input  logic              done,
    input  vrp_pkg::result_t  result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_data,
    output int                failures,
    output int                outstanding,
    output int                results_seen
);
    import vrp_pkg::*;

    logic [7:0]  pattern_mem [PATTERN_DEPTH];
    logic [7:0]  name_mem    [NAME_DEPTH];
    logic [7:0]  palette_mem [PALETTE_DEPTH];
    logic [7:0]  sprite_mem  [SPRITE_DEPTH];
    logic [15:0] vaddr;
    logic [7:0]  delayed_byte;
    logic        second_write;
    logic        status_toggle;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
    logic        row_step;
    result_t     pending_results [$];

    function automatic logic [PALETTE_AW-1:0] palette_slot(logic [15:0] a);
        logic [PALETTE_AW-1:0] s;
        s = a[PALETTE_AW-1:0];
        // The four sprite backdrop entries share storage with the background ones.
        if (s[4] && s[1:0] == 2'b00)
            s[4] = 1'b0;
        return s;
    endfunction

    function automatic logic [7:0] vram_fetch(logic [15:0] a);
        logic [15:0] offset;
        offset = a - NAME_BASE;
        if (a < NAME_BASE)
            return pattern_mem[a[PATTERN_AW-1:0]];
        else if (a < PALETTE_BASE)
            return name_mem[offset[NAME_AW-1:0]];
        else if (a < VRAM_LIMIT)
            return palette_mem[palette_slot(a)];
        return 8'h00;
    endfunction

    task automatic vram_store(input logic [15:0] a, input logic [7:0] v);
        logic [15:0] offset;
        offset = a - NAME_BASE;
        if (a >= NAME_BASE && a < PALETTE_BASE)
            name_mem[offset[NAME_AW-1:0]] = v;
        else if (a >= PALETTE_BASE && a < VRAM_LIMIT)
            palette_mem[palette_slot(a)] = v;
    endtask

    task automatic predict_access(input request_t r, output result_t res);
        logic [7:0] value;
        value = 8'h00;
        case (r.opcode)
            OP_READ_STATUS:
            begin
                status_toggle = ~status_toggle;
                second_write  = 1'b0;
                value = status_toggle ? 8'h00 : STATUS_SET;
            end
            OP_READ_SPRITE:
                value = sprite_mem[r.sprite_index[SPRITE_AW-1:0]];
            OP_READ_DATA:
            begin
                value        = delayed_byte;
                delayed_byte = vram_fetch(vaddr);
                vaddr        = vaddr + (row_step ? STEP_ROW : STEP_ONE);
            end
            OP_WRITE_SCROLL:
            begin
                if (second_write)
                    scroll_y = r.data_byte;
                else
                    scroll_x = r.data_byte;
                second_write = ~second_write;
            end
            OP_WRITE_ADDR:
            begin
                if (second_write)
                    vaddr[7:0] = r.data_byte;
                else
                    vaddr[15:8] = r.data_byte;
                second_write = ~second_write;
            end
            OP_WRITE_DATA:
            begin
                vram_store(vaddr, r.data_byte);
                vaddr = vaddr + (row_step ? STEP_ROW : STEP_ONE);
            end
            OP_WRITE_SPRITE:
                sprite_mem[r.sprite_index[SPRITE_AW-1:0]] = r.data_byte;
            default:
                pattern_mem[r.pattern_address[PATTERN_AW-1:0]] = r.data_byte;
        endcase
        res.read_value        = value;
        res.scroll_horizontal = scroll_x;
        res.scroll_vertical   = scroll_y;
        res.video_address     = vaddr;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        failures++;
        if (failures <= 40)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NAME_DEPTH; i++)
                name_mem[i] = 8'h00;
            for (int i = 0; i < PALETTE_DEPTH; i++)
                palette_mem[i] = 8'h00;
            for (int i = 0; i < SPRITE_DEPTH; i++)
                sprite_mem[i] = 8'h00;
            vaddr         = '0;
            delayed_byte  = '0;
            second_write  = 1'b0;
            status_toggle = 1'b0;
            scroll_x      = '0;
            scroll_y      = '0;
            row_step      = 1'b0;
            pending_results.delete();
            failures      = 0;
            outstanding   = 0;
            results_seen  = 0;
        end
        else
        begin
            // Results are matched before a new access is predicted, so a result
            // can never be paired with the access accepted at the same edge.
            if (done)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch("result with no access pending", result.video_address,
                                    16'h0000);
                else
                begin
                    want = pending_results.pop_front();
                    if (result.read_value !== want.read_value)
                        report_mismatch("read_value", 16'(result.read_value),
                                        16'(want.read_value));
                    if (result.scroll_horizontal !== want.scroll_horizontal)
                        report_mismatch("scroll_horizontal", 16'(result.scroll_horizontal),
                                        16'(want.scroll_horizontal));
                    if (result.scroll_vertical !== want.scroll_vertical)
                        report_mismatch("scroll_vertical", 16'(result.scroll_vertical),
                                        16'(want.scroll_vertical));
                    if (result.video_address !== want.video_address)
                        report_mismatch("video_address", result.video_address,
                                        want.video_address);
                end
            end
            if (cfg_valid && cfg_ready)
                row_step = cfg_data;
            if (start && !busy)
            begin
                predict_access(request, want);
                pending_results.push_back(want);
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video register port testbench
// Drives bus accesses and increment settings into the port, with directed
// corner cases first and then randomized access sequences in bursts.
// ----------------------------------------------------------------------------
module tb_top;
    import vrp_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int STALL_LIMIT     = 8000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     start     = 1'b0;
    request_t request   = '0;
    logic     cfg_valid = 1'b0;
    logic     cfg_data  = 1'b0;
    logic     busy;
    logic     done;
    logic     cfg_ready;
    result_t  result;
    int       failures;
    int       outstanding;
    int       results_seen;

    // Just enough of the port's state to keep data reads off pattern entries
    // that were never loaded.
    logic [15:0] bus_address = '0;
    logic        addr_second = 1'b0;
    logic        step_by_row = 1'b0;
    bit          pattern_loaded [PATTERN_DEPTH];

    int burst_left   = 0;
    int accesses     = 0;
    int cfg_writes   = 0;
    int quiet_cycles = 0;

    video_register_port dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    vrp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .done         (done),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("No transfer for %0d cycles, giving up.", STALL_LIMIT);
            $display("video_register_port verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic request_t compose(logic [2:0] op, logic [7:0] data);
        request_t r;
        r.opcode          = op;
        r.data_byte       = data;
        r.sprite_index    = 8'($urandom_range(0, 255));
        r.pattern_address = PATTERN_AW'($urandom_range(0, PATTERN_DEPTH - 1));
        return r;
    endfunction

    function automatic logic [7:0] pick_high_byte();
        int          pick;
        logic [7:0]  hb;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            hb = 8'($urandom_range(0, NAME_BASE[15:8] - 1));
        else if (pick < 55)
            hb = 8'($urandom_range(NAME_BASE[15:8], PALETTE_BASE[15:8] - 1));
        else if (pick < 85)
            hb = PALETTE_BASE[15:8];
        else
            hb = 8'($urandom_range(VRAM_LIMIT[15:8], 255));
        return hb;
    endfunction

    task automatic track_access(input request_t r);
        case (r.opcode)
            OP_READ_STATUS:
                addr_second = 1'b0;
            OP_READ_DATA, OP_WRITE_DATA:
                bus_address = bus_address + (step_by_row ? STEP_ROW : STEP_ONE);
            OP_WRITE_SCROLL:
                addr_second = ~addr_second;
            OP_WRITE_ADDR:
            begin
                if (addr_second)
                    bus_address[7:0] = r.data_byte;
                else
                    bus_address[15:8] = r.data_byte;
                addr_second = ~addr_second;
            end
            OP_LOAD_PATTERN:
                pattern_loaded[r.pattern_address[PATTERN_AW-1:0]] = 1'b1;
            default:
                ;
        endcase
    endtask

    // Sends one access in the current burst, opening a new burst after a gap
    // when the old one is used up.
    task automatic issue(input request_t r);
        int gap;
        // A data read from a pattern entry that was never loaded is not allowed,
        // so the entry is loaded instead; the next read then finds it.
        if (r.opcode == OP_READ_DATA && bus_address < NAME_BASE
            && !pattern_loaded[bus_address[PATTERN_AW-1:0]])
        begin
            r.opcode          = OP_LOAD_PATTERN;
            r.pattern_address = bus_address[PATTERN_AW-1:0];
        end
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            start   <= 1'b0;
            request <= compose(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        request <= r;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        track_access(r);
        accesses++;
    endtask

    task automatic go_quiet();
        @(negedge clk);
        start <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic set_row_step(input logic row);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= row;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        step_by_row = row;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_sequence();
        request_t   r;
        int         kind;
        int         run;
        int         mode;
        logic [2:0] op;
        logic [PATTERN_AW-1:0] base;
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            // Usual data transfer: a latch reset (most of the time), both address bytes, then a run.
            if ($urandom_range(0, 3) != 0)
                issue(compose(OP_READ_STATUS, 8'($urandom_range(0, 255))));
            issue(compose(OP_WRITE_ADDR, pick_high_byte()));
            issue(compose(OP_WRITE_ADDR, 8'($urandom_range(0, 255))));
            run  = $urandom_range(1, 6);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < run; i++)
            begin
                if (mode == 0 || (mode == 2 && $urandom_range(0, 1) == 1))
                    op = OP_READ_DATA;
                else
                    op = OP_WRITE_DATA;
                issue(compose(op, 8'($urandom_range(0, 255))));
            end
        end
        else if (kind < 65)
        begin
            if ($urandom_range(0, 3) != 0)
                issue(compose(OP_READ_STATUS, 8'($urandom_range(0, 255))));
            issue(compose(OP_WRITE_SCROLL, 8'($urandom_range(0, 255))));
            issue(compose(OP_WRITE_SCROLL, 8'($urandom_range(0, 255))));
        end
        else if (kind < 80)
        begin
            run = $urandom_range(1, 4);
            for (int i = 0; i < run; i++)
            begin
                r = compose(OP_WRITE_SPRITE, 8'($urandom_range(0, 255)));
                issue(r);
                if ($urandom_range(0, 1) == 1)
                    r.opcode = OP_READ_SPRITE;
                else
                    r = compose(OP_READ_SPRITE, 8'($urandom_range(0, 255)));
                issue(r);
            end
        end
        else if (kind < 90)
        begin
            if (bus_address < NAME_BASE && $urandom_range(0, 1) == 1)
                base = bus_address[PATTERN_AW-1:0];
            else
                base = PATTERN_AW'($urandom_range(0, PATTERN_DEPTH - 1));
            run = $urandom_range(1, 4);
            for (int i = 0; i < run; i++)
            begin
                r = compose(OP_LOAD_PATTERN, 8'($urandom_range(0, 255)));
                r.pattern_address = base + PATTERN_AW'(i);
                issue(r);
            end
        end
        else
            issue(compose(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
    endtask

    initial
    begin
        request_t r;
        int       target;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_row_step(1'b0);

        // Status phase alternation, then scroll bytes at both extremes.
        issue(compose(OP_READ_STATUS, 8'h00));
        issue(compose(OP_READ_STATUS, 8'hFF));
        issue(compose(OP_WRITE_SCROLL, 8'h00));
        issue(compose(OP_WRITE_SCROLL, 8'hFF));
        // A write to a mirrored palette entry, read back through its twin.
        issue(compose(OP_WRITE_ADDR, PALETTE_BASE[15:8]));
        issue(compose(OP_WRITE_ADDR, 8'h10));
        issue(compose(OP_WRITE_DATA, 8'hAA));
        issue(compose(OP_READ_STATUS, 8'h00));
        issue(compose(OP_WRITE_ADDR, PALETTE_BASE[15:8]));
        issue(compose(OP_WRITE_ADDR, 8'h00));
        issue(compose(OP_READ_DATA, 8'h00));
        issue(compose(OP_READ_DATA, 8'h00));
        // Sprite store at its top index.
        r = compose(OP_WRITE_SPRITE, 8'h5A);
        r.sprite_index = 8'hFF;
        issue(r);
        r.opcode = OP_READ_SPRITE;
        issue(r);
        // Pattern store at both ends, then read from the top of the range.
        r = compose(OP_LOAD_PATTERN, 8'hFF);
        r.pattern_address = PATTERN_AW'(PATTERN_DEPTH - 1);
        issue(r);
        r = compose(OP_LOAD_PATTERN, 8'h00);
        r.pattern_address = '0;
        issue(r);
        issue(compose(OP_WRITE_ADDR, 8'h1F));
        issue(compose(OP_WRITE_ADDR, 8'hFF));
        issue(compose(OP_READ_DATA, 8'h00));
        // Beyond video memory: zero refill and the 16-bit wrap to address zero,
        // then a write into the pattern range that must be dropped.
        issue(compose(OP_WRITE_ADDR, 8'hFF));
        issue(compose(OP_WRITE_ADDR, 8'hFF));
        issue(compose(OP_READ_DATA, 8'h00));
        issue(compose(OP_READ_DATA, 8'h00));
        issue(compose(OP_WRITE_DATA, 8'h77));
        go_quiet();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_row_step(phase % 2 == 0);
            target = accesses + ITEMS_PER_PHASE;
            while (accesses < target)
                random_sequence();
            go_quiet();
        end

        repeat (8) @(negedge clk);
        $display("Covered %0d bus accesses under %0d increment writes (steps of 1 and 32).",
                 accesses, cfg_writes);
        $display("Compared %0d results field by field; %0d mismatches.", results_seen,
                 failures);
        if (failures == 0)
            $display("video_register_port verification clean");
        else
            $display("video_register_port verification failed");
        $finish;
    end

endmodule
